@@ hdl/assert_macros.svh @@
// assertion macros for the top-level rtl file
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// expression must never be true
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ hdl/bpc_pkg.sv @@
// package for the pressure compensation block: constants, register
// indexes, shift and sign-extend helpers; no dependencies
package bpc_pkg;

   localparam int DATA_W  = 32;
   localparam int DIV_W   = 32;
   localparam int UT_W    = 16;
   localparam int UP_W    = 19;
   localparam int OSS_W   = 2;
   localparam int CSR_IDX_W = 3;

   // depth from input transfer to result: both dividers plus 13 other stages
   localparam int LATENCY = 2 * DIV_W + 13;

   // calibration reset words
   localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
   localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
   localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
   localparam logic [31:0] RST_B1_B2   = 32'd405667844;
   localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

   // formula constants
   localparam logic [31:0] K_B6_OFS   = 32'd4000;
   localparam logic [31:0] K_B4_OFS   = 32'd32768;
   localparam logic [31:0] K_B7_SCALE = 32'd50000;
   localparam logic [31:0] K_P_SQ     = 32'd3038;
   localparam logic [31:0] K_P_LIN    = 32'hFFFF_E343;  // -7357
   localparam logic [31:0] K_P_OFS    = 32'd3791;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_AC1_AC2 = 3'd0,
      REG_AC3_AC4 = 3'd1,
      REG_AC5_AC6 = 3'd2,
      REG_B1_B2   = 3'd3,
      REG_MC_MD   = 3'd4
   } reg_idx_type;

   // arithmetic shift right of a 32-bit word
   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
      return $signed(v) >>> n;
   endfunction

   // sign-extend a 16-bit half
   function automatic logic [31:0] sx16(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

endpackage

@@ hdl/bpc_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on nothing; divide by zero gives all ones, caller flags it
module bpc_div_pipe #(
   parameter int DW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem_ff  [DW];
   logic [DW-1:0] nq_ff   [DW];
   logic [DW-1:0] den_ff  [DW];
   logic [SW-1:0] side_ff [DW];
   logic [DW-1:0] vld_ff;

   for (genvar i = 0; i < DW; i++) begin : g_stage
      logic [DW-1:0] rem_p, nq_p, den_p, rem_in, nq_in;
      logic [SW-1:0] side_p;
      logic          vld_p;
      logic [DW:0]   trial, diff;

      // stage inputs: ports for the first step, previous stage otherwise
      if (i == 0) begin : g_first
         assign rem_p  = '0;
         assign nq_p   = in_num;
         assign den_p  = in_den;
         assign side_p = in_side;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign nq_p   = nq_ff[i-1];
         assign den_p  = den_ff[i-1];
         assign side_p = side_ff[i-1];
         assign vld_p  = vld_ff[i-1];
      end

      // one trial subtract
      always_comb begin
         trial = {rem_p, nq_p[DW-1]};
         diff  = trial - {1'b0, den_p};
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            nq_in  = {nq_p[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            nq_in  = {nq_p[DW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         nq_ff[i]   <= nq_in;
         den_ff[i]  <= den_p;
         side_ff[i] <= side_p;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_p;
         end
      end
   end

   assign out_valid = vld_ff[DW-1];
   assign out_quo   = nq_ff[DW-1];
   assign out_side  = side_ff[DW-1];

endmodule

@@ hdl/barometric_pressure_compensation.sv @@
// top level of the pressure compensation pipeline: calibration registers,
// arithmetic stages and two pipelined dividers; uses bpc_pkg, bpc_div_pipe
//
//  port group | dir | transfer when
//  req_*      | in  | start high and busy low at a rising edge
//  rsp_*      | out | rsp_valid high, one cycle, no back pressure
//  csr_*      | in  | csr_we high at a rising edge
//
// one item per cycle; between a transfer and its result lie 13 registered
// stages besides the two 32-stage dividers, as bpc_pkg::LATENCY counts them
// busy is high only during reset; reset drops items in flight and restores
// the calibration words. the pipeline never stalls.
`include "assert_macros.svh"

module barometric_pressure_compensation (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bpc_pkg::UT_W-1:0]     req_raw_temperature,
   input  logic [bpc_pkg::UP_W-1:0]     req_raw_pressure,
   input  logic [bpc_pkg::OSS_W-1:0]    req_oversampling,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_temperature,
   output logic signed [31:0]           rsp_pressure,
   output logic                         rsp_divide_error,
   input  logic                         csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                  csr_wdata
);
   import bpc_pkg::*;

   localparam int S1_W = UP_W + OSS_W + 32 + 2;
   localparam int S2_W = 32 + 2;

   // calibration registers
   logic [31:0] cal0_ff, cal1_ff, cal2_ff, cal3_ff, cal4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal0_ff <= RST_AC1_AC2;
         cal1_ff <= RST_AC3_AC4;
         cal2_ff <= RST_AC5_AC6;
         cal3_ff <= RST_B1_B2;
         cal4_ff <= RST_MC_MD;
      end else if (csr_we) begin
         case (csr_index)
            REG_AC1_AC2: cal0_ff <= csr_wdata;
            REG_AC3_AC4: cal1_ff <= csr_wdata;
            REG_AC5_AC6: cal2_ff <= csr_wdata;
            REG_B1_B2:   cal3_ff <= csr_wdata;
            REG_MC_MD:   cal4_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(cal0_ff[31:16]);
   assign ac2 = sx16(cal0_ff[15:0]);
   assign ac3 = sx16(cal1_ff[31:16]);
   assign ac4 = {16'b0, cal1_ff[15:0]};
   assign ac5 = {16'b0, cal2_ff[31:16]};
   assign ac6 = {16'b0, cal2_ff[15:0]};
   assign b1  = sx16(cal3_ff[31:16]);
   assign b2  = sx16(cal3_ff[15:0]);
   assign mc  = sx16(cal4_ff[31:16]);
   assign md  = sx16(cal4_ff[15:0]);

   assign busy = reset;

   // valid chain outside the dividers
   logic v_in_ff, v_m_ff, v_pre_ff, v_b5_ff, v_sq_ff, v_b_ff, v_c_ff, v_d_ff;
   logic v_e_ff, v_p_ff, v_m1_ff, v_m2_ff, rsp_valid_ff;
   logic d1_valid, d2_valid;

   // input capture
   logic [UT_W-1:0]  ut_ff;
   logic [UP_W-1:0]  up_ff, up_m_ff, up_pre_ff;
   logic [OSS_W-1:0] oss_ff, oss_m_ff, oss_pre_ff;

   always_ff @(posedge clock) begin
      ut_ff  <= req_raw_temperature;
      up_ff  <= req_raw_pressure;
      oss_ff <= req_oversampling;
   end

   // stage: (ut - ac6) * ac5
   logic [31:0] m_in, m_ff;
   assign m_in = ({16'b0, ut_ff} - ac6) * ac5;

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      up_m_ff  <= up_ff;
      oss_m_ff <= oss_ff;
   end

   // stage: temperature divisor, magnitudes and signs
   logic [31:0] x1t, den, num, an_in, ad_in, an_ff, ad_ff, x1t_ff;
   logic        neg_in, zero_in, neg_ff, zero_ff;

   always_comb begin
      x1t     = asr(m_ff, 5'd15);
      den     = x1t + md;
      num     = {mc[20:0], 11'b0};
      neg_in  = num[31] ^ den[31];
      zero_in = (den == '0);
      an_in   = num[31] ? (32'd0 - num) : num;
      ad_in   = den[31] ? (32'd0 - den) : den;
   end

   always_ff @(posedge clock) begin
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      x1t_ff     <= x1t;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      up_pre_ff  <= up_m_ff;
      oss_pre_ff <= oss_m_ff;
   end

   // temperature divider
   logic [31:0]   q1;
   logic [S1_W-1:0] s1_in, s1_out;
   assign s1_in = {up_pre_ff, oss_pre_ff, x1t_ff, neg_ff, zero_ff};

   bpc_div_pipe #(.DW(DIV_W), .SW(S1_W)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v_pre_ff),
      .in_num   (an_ff),
      .in_den   (ad_ff),
      .in_side  (s1_in),
      .out_valid(d1_valid),
      .out_quo  (q1),
      .out_side (s1_out)
   );

   logic [UP_W-1:0]  d1_up;
   logic [OSS_W-1:0] d1_oss;
   logic [31:0]      d1_x1;
   logic             d1_neg, d1_zero;
   assign {d1_up, d1_oss, d1_x1, d1_neg, d1_zero} = s1_out;

   // stage: b5 and temperature
   logic [31:0] b5_in, b5_ff, t_in, t_b5_ff;
   logic [UP_W-1:0]  up_b5_ff;
   logic [OSS_W-1:0] oss_b5_ff;
   logic             err_b5_ff;

   always_comb begin
      b5_in = d1_x1 + (d1_neg ? (32'd0 - q1) : q1);
      t_in  = asr(b5_in + 32'd8, 5'd4);
   end

   always_ff @(posedge clock) begin
      b5_ff     <= b5_in;
      t_b5_ff   <= t_in;
      up_b5_ff  <= d1_up;
      oss_b5_ff <= d1_oss;
      err_b5_ff <= d1_zero;
   end

   // stage: b6 products
   logic [31:0] b6, sqr_ff, p2_ff, p3_ff, t_sq_ff;
   logic [UP_W-1:0]  up_sq_ff;
   logic [OSS_W-1:0] oss_sq_ff;
   logic             err_sq_ff;
   assign b6 = b5_ff - K_B6_OFS;

   always_ff @(posedge clock) begin
      sqr_ff    <= b6 * b6;
      p2_ff     <= ac2 * b6;
      p3_ff     <= ac3 * b6;
      t_sq_ff   <= t_b5_ff;
      up_sq_ff  <= up_b5_ff;
      oss_sq_ff <= oss_b5_ff;
      err_sq_ff <= err_b5_ff;
   end

   // stage: products with the squared term
   logic [31:0] sq, b2sq_ff, b1sq_ff, x2p_ff, x1c_ff, t_b_ff;
   logic [UP_W-1:0]  up_b_ff;
   logic [OSS_W-1:0] oss_b_ff;
   logic             err_b_ff;
   assign sq = asr(sqr_ff, 5'd12);

   always_ff @(posedge clock) begin
      b2sq_ff  <= b2 * sq;
      b1sq_ff  <= b1 * sq;
      x2p_ff   <= asr(p2_ff, 5'd11);
      x1c_ff   <= asr(p3_ff, 5'd13);
      t_b_ff   <= t_sq_ff;
      up_b_ff  <= up_sq_ff;
      oss_b_ff <= oss_sq_ff;
      err_b_ff <= err_sq_ff;
   end

   // stage: b3 and b4 operand
   logic [31:0] x3a, x3b, b3_in, t3_in, b3_ff, t3_ff, t_c_ff;
   logic [UP_W-1:0]  up_c_ff;
   logic [OSS_W-1:0] oss_c_ff;
   logic             err_c_ff;

   always_comb begin
      x3a   = asr(b2sq_ff, 5'd11) + x2p_ff;
      b3_in = asr((({ac1[29:0], 2'b0} + x3a) << oss_b_ff) + 32'd2, 5'd2);
      x3b   = asr(x1c_ff + asr(b1sq_ff, 5'd16) + 32'd2, 5'd2);
      t3_in = x3b + K_B4_OFS;
   end

   always_ff @(posedge clock) begin
      b3_ff    <= b3_in;
      t3_ff    <= t3_in;
      t_c_ff   <= t_b_ff;
      up_c_ff  <= up_b_ff;
      oss_c_ff <= oss_b_ff;
      err_c_ff <= err_b_ff;
   end

   // stage: b4 and up - b3
   logic [31:0] b4p, b4_d_ff, dif_ff, t_d_ff;
   logic [OSS_W-1:0] oss_d_ff;
   logic             err_d_ff;
   assign b4p = ac4 * t3_ff;

   always_ff @(posedge clock) begin
      b4_d_ff  <= b4p >> 15;
      dif_ff   <= {{(32-UP_W){1'b0}}, up_c_ff} - b3_ff;
      t_d_ff   <= t_c_ff;
      oss_d_ff <= oss_c_ff;
      err_d_ff <= err_c_ff;
   end

   // stage: b7
   logic [31:0] b7_ff, b4_e_ff, t_e_ff;
   logic        err_e_ff;

   always_ff @(posedge clock) begin
      b7_ff    <= dif_ff * (K_B7_SCALE >> oss_d_ff);
      b4_e_ff  <= b4_d_ff;
      t_e_ff   <= t_d_ff;
      err_e_ff <= err_d_ff;
   end

   // pressure divider, numerator form chosen by the top bit of b7
   logic [31:0]     num2, q2;
   logic [S2_W-1:0] s2_in, s2_out;
   logic            hi, d2_hi, d2_err;
   logic [31:0]     d2_t;
   assign hi    = b7_ff[31];
   assign num2  = hi ? b7_ff : {b7_ff[30:0], 1'b0};
   assign s2_in = {t_e_ff, hi, err_e_ff | (b4_e_ff == '0)};

   bpc_div_pipe #(.DW(DIV_W), .SW(S2_W)) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v_e_ff),
      .in_num   (num2),
      .in_den   (b4_e_ff),
      .in_side  (s2_in),
      .out_valid(d2_valid),
      .out_quo  (q2),
      .out_side (s2_out)
   );

   assign {d2_t, d2_hi, d2_err} = s2_out;

   // stage: raw pressure
   logic [31:0] p_ff, t_p_ff;
   logic        err_p_ff;

   always_ff @(posedge clock) begin
      p_ff     <= d2_hi ? (q2 >> 1) : q2;
      t_p_ff   <= d2_t;
      err_p_ff <= d2_err;
   end

   // stage: square and linear terms
   logic [31:0] pa, aa_ff, x2m_ff, p_m1_ff, t_m1_ff;
   logic        err_m1_ff;
   assign pa = asr(p_ff, 5'd8);

   always_ff @(posedge clock) begin
      aa_ff     <= pa * pa;
      x2m_ff    <= K_P_LIN * p_ff;
      p_m1_ff   <= p_ff;
      t_m1_ff   <= t_p_ff;
      err_m1_ff <= err_p_ff;
   end

   // stage: scale square term
   logic [31:0] prod_ff, x2m_m2_ff, p_m2_ff, t_m2_ff;
   logic        err_m2_ff;

   always_ff @(posedge clock) begin
      prod_ff   <= aa_ff * K_P_SQ;
      x2m_m2_ff <= x2m_ff;
      p_m2_ff   <= p_m1_ff;
      t_m2_ff   <= t_m1_ff;
      err_m2_ff <= err_m1_ff;
   end

   // output stage
   logic [31:0] pf_in, rsp_t_ff, rsp_p_ff;
   logic        rsp_err_ff;
   assign pf_in = p_m2_ff
                + asr(asr(prod_ff, 5'd16) + asr(x2m_m2_ff, 5'd16) + K_P_OFS, 5'd4);

   always_ff @(posedge clock) begin
      rsp_t_ff   <= err_m2_ff ? '0 : t_m2_ff;
      rsp_p_ff   <= err_m2_ff ? '0 : pf_in;
      rsp_err_ff <= err_m2_ff & v_m2_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff      <= 1'b0;
         v_m_ff       <= 1'b0;
         v_pre_ff     <= 1'b0;
         v_b5_ff      <= 1'b0;
         v_sq_ff      <= 1'b0;
         v_b_ff       <= 1'b0;
         v_c_ff       <= 1'b0;
         v_d_ff       <= 1'b0;
         v_e_ff       <= 1'b0;
         v_p_ff       <= 1'b0;
         v_m1_ff      <= 1'b0;
         v_m2_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_in_ff      <= start & ~busy;
         v_m_ff       <= v_in_ff;
         v_pre_ff     <= v_m_ff;
         v_b5_ff      <= d1_valid;
         v_sq_ff      <= v_b5_ff;
         v_b_ff       <= v_sq_ff;
         v_c_ff       <= v_b_ff;
         v_d_ff       <= v_c_ff;
         v_e_ff       <= v_d_ff;
         v_p_ff       <= d2_valid;
         v_m1_ff      <= v_p_ff;
         v_m2_ff      <= v_m1_ff;
         rsp_valid_ff <= v_m2_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temperature  = rsp_t_ff;
   assign rsp_pressure     = rsp_p_ff;
   assign rsp_divide_error = rsp_err_ff;

   // checks
   `ASSERT_IMPLY(a_err_zero, clock, reset, rsp_divide_error, rsp_temperature == 0 && rsp_pressure == 0)
   `ASSERT_NEVER(a_err_idle, clock, reset, !rsp_valid && rsp_divide_error)
   `ASSERT_IMPLY(a_latency, clock, reset, rsp_valid, $past(start && !busy, LATENCY))

endmodule

@@ test/tb.sv @@
// self-checking testbench for barometric_pressure_compensation
// drives raw sample transfers and calibration writes, predicts each reading
// and checks it; depends on bpc_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;
   import bpc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;   // no register behind it

   typedef struct {
      logic [UT_W-1:0]  raw_temperature;
      logic [UP_W-1:0]  raw_pressure;
      logic [OSS_W-1:0] oversampling;
   } sample_type;

   typedef struct {
      logic [31:0] temperature;
      logic [31:0] pressure;
      logic        divide_error;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [UT_W-1:0]  req_raw_temperature = '0;
   logic [UP_W-1:0]  req_raw_pressure = '0;
   logic [OSS_W-1:0] req_oversampling = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_temperature;
   logic signed [31:0] rsp_pressure;
   logic rsp_divide_error;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   sample_type  sample_on_port;
   logic [31:0] cal_words [5];
   logic taken = 1'b0;
   bit   idle_enable = 1'b0;
   int   gap_left = 0;
   int   errors = 0;
   int   cycles = 0;

   barometric_pressure_compensation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_temperature(req_raw_temperature), .req_raw_pressure(req_raw_pressure),
      .req_oversampling(req_oversampling), .rsp_valid(rsp_valid),
      .rsp_temperature(rsp_temperature), .rsp_pressure(rsp_pressure),
      .rsp_divide_error(rsp_divide_error), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] shift_arith(input logic [31:0] v, input int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   // signed divide, truncating toward zero
   function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
      logic [31:0] an, ad, q;
      an = n[31] ? 32'd0 - n : n;
      ad = d[31] ? 32'd0 - d : d;
      q = an / ad;
      return (n[31] != d[31]) ? 32'd0 - q : q;
   endfunction

   // compensated temperature and pressure for one raw sample
   function automatic reading_type compensate(input sample_type s);
      logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, p, t, den, sq;
      reading_type r;
      r.temperature = '0;
      r.pressure = '0;
      r.divide_error = 1'b1;
      ut = {16'd0, s.raw_temperature};
      up = {13'd0, s.raw_pressure};
      ac1 = widen_half(cal_words[REG_AC1_AC2][31:16]);
      ac2 = widen_half(cal_words[REG_AC1_AC2][15:0]);
      ac3 = widen_half(cal_words[REG_AC3_AC4][31:16]);
      ac4 = {16'd0, cal_words[REG_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_words[REG_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_words[REG_AC5_AC6][15:0]};
      b1 = widen_half(cal_words[REG_B1_B2][31:16]);
      b2 = widen_half(cal_words[REG_B1_B2][15:0]);
      mc = widen_half(cal_words[REG_MC_MD][31:16]);
      md = widen_half(cal_words[REG_MC_MD][15:0]);
      // temperature
      x1 = shift_arith((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 32'd0) return r;
      x2 = div_trunc(mc << 11, den);
      b5 = x1 + x2;
      t = shift_arith(b5 + 32'd8, 4);
      // pressure
      b6 = b5 - K_B6_OFS;
      sq = shift_arith(b6 * b6, 12);
      x1 = shift_arith(b2 * sq, 11);
      x2 = shift_arith(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shift_arith(((ac1 * 32'd4 + x3) << s.oversampling) + 32'd2, 2);
      x1 = shift_arith(ac3 * b6, 13);
      x2 = shift_arith(b1 * sq, 16);
      x3 = shift_arith(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + K_B4_OFS)) >> 15;
      if (b4 == 32'd0) return r;
      b7 = (up - b3) * (K_B7_SCALE >> s.oversampling);
      // two ways of dividing, picked by the top bit of b7
      if (!b7[31]) p = (b7 << 1) / b4;
      else p = (b7 / b4) >> 1;
      x1 = shift_arith(p, 8) * shift_arith(p, 8);
      x1 = shift_arith(x1 * K_P_SQ, 16);
      x2 = shift_arith(K_P_LIN * p, 16);
      p = p + shift_arith(x1 + x2 + K_P_OFS, 4);
      r.temperature = t;
      r.pressure = p;
      r.divide_error = 1'b0;
      return r;
   endfunction

   // input transfer: record it and queue the predicted reading
   always @(posedge clock) begin
      cycles <= cycles + 1;
      taken <= start && !busy && !reset;
      if (start && !busy && !reset)
         expected_readings.push_back(compensate(sample_on_port));
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // result transfer: check against the oldest prediction
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid) begin
         if (expected_readings.size() == 0) begin
            $error("reading with none expected");
            errors++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_temperature !== want.temperature) begin
               $error("temperature: expected %0d, got %0d",
                      $signed(want.temperature), rsp_temperature);
               errors++;
            end
            if (rsp_pressure !== want.pressure) begin
               $error("pressure: expected %0d, got %0d",
                      $signed(want.pressure), rsp_pressure);
               errors++;
            end
            if (rsp_divide_error !== want.divide_error) begin
               $error("divide_error: expected %0b, got %0b",
                      want.divide_error, rsp_divide_error);
               errors++;
            end
         end
      end
   end

   // driver: holds start until the transfer, then idles a random gap when idle_enable is set
   always @(negedge clock) begin
      sample_type s;
      logic next_start;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
      end else if (!start || taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            next_start = 1'b0;
         end else if (pending_samples.size() > 0) begin
            s = pending_samples.pop_front();
            sample_on_port <= s;
            req_raw_temperature <= s.raw_temperature;
            req_raw_pressure <= s.raw_pressure;
            req_oversampling <= s.oversampling;
            next_start = 1'b1;
            gap_left <= idle_enable ? $urandom_range(0, 16) : 0;
         end else begin
            next_start = 1'b0;
         end
      end
      start <= next_start;
   end

   task automatic write_cal(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx <= REG_MC_MD) cal_words[idx] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all_cal(input logic [31:0] w0, input logic [31:0] w1,
                                input logic [31:0] w2, input logic [31:0] w3,
                                input logic [31:0] w4);
      write_cal(REG_AC1_AC2, w0);
      write_cal(REG_AC3_AC4, w1);
      write_cal(REG_AC5_AC6, w2);
      write_cal(REG_B1_B2, w3);
      write_cal(REG_MC_MD, w4);
   endtask

   task automatic add_sample(input logic [UT_W-1:0] ut, input logic [UP_W-1:0] up,
                             input logic [OSS_W-1:0] oss);
      sample_type s;
      s.raw_temperature = ut;
      s.raw_pressure = up;
      s.oversampling = oss;
      pending_samples.push_back(s);
   endtask

   task automatic add_random(input int count);
      logic [UT_W-1:0] ut;
      logic [UP_W-1:0] up;
      for (int i = 0; i < count; i++) begin
         ut = UT_W'($urandom_range(0, 65535));
         up = UP_W'($urandom_range(0, 524287));
         if ($urandom_range(0, 9) == 0) ut = $urandom_range(0, 1) ? '1 : '0;
         if ($urandom_range(0, 9) == 0) up = $urandom_range(0, 1) ? '1 : '0;
         if ($urandom_range(0, 2) == 0) begin
            // sensor-like readings around room conditions
            ut = UT_W'($urandom_range(20000, 36000));
            up = UP_W'($urandom_range(20000, 45000) << $urandom_range(0, 3));
         end
         add_sample(ut, up, OSS_W'($urandom_range(0, 3)));
      end
   endtask

   // wait for the driver to drain and every reading to come back
   task automatic drain();
      @(posedge clock);
      while (pending_samples.size() > 0 || start) @(posedge clock);
      while (expected_readings.size() > 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   initial begin
      cal_words[REG_AC1_AC2] = RST_AC1_AC2;
      cal_words[REG_AC3_AC4] = RST_AC3_AC4;
      cal_words[REG_AC5_AC6] = RST_AC5_AC6;
      cal_words[REG_B1_B2] = RST_B1_B2;
      cal_words[REG_MC_MD] = RST_MC_MD;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset calibration, field extremes, every oversampling
      add_sample(16'd27898, 19'd23843, 2'd0);
      add_sample('0, '0, 2'd0);
      add_sample('1, '1, 2'd3);
      add_sample('0, '1, 2'd1);
      add_sample('1, '0, 2'd2);
      for (int o = 0; o < 4; o++) add_sample(16'd27898, 19'd23843 << o, o[1:0]);
      drain();

      // zero temperature divisor: ac5 and md zero
      write_all_cal(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      add_sample(16'd1234, 19'd5678, 2'd1);
      add_sample('1, '1, 2'd3);
      drain();

      // zero pressure divisor: ac4 zero, md nonzero
      write_all_cal(RST_AC1_AC2, RST_AC3_AC4 & 32'hFFFF_0000, RST_AC5_AC6,
                    RST_B1_B2, RST_MC_MD);
      add_sample(16'd27898, 19'd23843, 2'd0);
      add_sample('0, '1, 2'd2);
      drain();

      // all ones, plus a write to an index with no register
      write_all_cal('1, '1, '1, '1, '1);
      write_cal(REG_SPARE, 32'h0);
      add_sample(16'd27898, 19'd23843, 2'd0);
      add_sample('1, '0, 2'd3);
      add_sample('0, '1, 2'd0);
      drain();

      // random phases: reset words, random calibration sets, all ones, reset words again
      write_all_cal(RST_AC1_AC2, RST_AC3_AC4, RST_AC5_AC6, RST_B1_B2, RST_MC_MD);
      idle_enable = 1'b0;
      add_random(150);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_all_cal($urandom, $urandom, $urandom, $urandom, $urandom);
         idle_enable = ph[0];
         add_random(60);
         idle_enable = !ph[0];
         add_random(60);
         drain();
      end
      write_all_cal('1, '1, '1, '1, '1);
      idle_enable = 1'b1;
      add_random(100);
      drain();
      write_all_cal(RST_AC1_AC2, RST_AC3_AC4, RST_AC5_AC6, RST_B1_B2, RST_MC_MD);
      idle_enable = 1'b0;
      add_random(50);
      drain();

      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
